FILE: rtl/pooled_linked_deque_top_defines.svh
// ----------------------------------------------------------------------------
// pooled linked deque assertion macros
// shared concurrent assertion forms, clocked on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef POOLED_LINKED_DEQUE_TOP_DEFINES_SVH
`define POOLED_LINKED_DEQUE_TOP_DEFINES_SVH

// condition must hold at every edge out of reset
`define PLD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PLD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// types, codes and sizes shared by the pooled linked deque modules
// ----------------------------------------------------------------------------
package pld_pkg;

    // pool size and derived widths
    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);

    // null link: one past the last slot
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BWD   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_LINK,
        ST_POP_RD,
        ST_POP_FREE,
        ST_LIST
    } state_t;

    // input beat
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_res;
        logic               last;
    } res_t;

    // classified command held in the queue
    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } qcmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: rtl/pld_front.sv
// ----------------------------------------------------------------------------
// pld_front
// takes input beats, decodes the kind and queues known operations
// ----------------------------------------------------------------------------
module pld_front (
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  pld_pkg::cmd_t   cmd,
    input  pld_pkg::qstat_t q_stat,
    output logic            q_push,
    output pld_pkg::qcmd_t  q_data
);

    logic known;

    always_comb
    begin
        known     = 1'b1;
        q_data.op = pld_pkg::OP_PUSH_FRONT;
        case (cmd.kind)
            pld_pkg::OP_PUSH_FRONT: q_data.op = pld_pkg::OP_PUSH_FRONT;
            pld_pkg::OP_PUSH_BACK:  q_data.op = pld_pkg::OP_PUSH_BACK;
            pld_pkg::OP_POP_FRONT:  q_data.op = pld_pkg::OP_POP_FRONT;
            pld_pkg::OP_POP_BACK:   q_data.op = pld_pkg::OP_POP_BACK;
            pld_pkg::OP_LIST_FWD:   q_data.op = pld_pkg::OP_LIST_FWD;
            pld_pkg::OP_LIST_BWD:   q_data.op = pld_pkg::OP_LIST_BWD;
            default:                known     = 1'b0;
        endcase
        q_data.value = cmd.value;
    end

    // unknown kinds are taken and dropped
    assign cmd_stall = q_stat.full;
    assign q_push    = cmd_valid && !q_stat.full && known;

endmodule

FILE: rtl/pld_cmd_queue.sv
// ----------------------------------------------------------------------------
// pld_cmd_queue
// small fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module pld_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pld_pkg::qcmd_t  push_data,
    input  logic            pop,
    output pld_pkg::qcmd_t  pop_data,
    output pld_pkg::qstat_t stat
);

    pld_pkg::qcmd_t                  store_reg [pld_pkg::QUEUE_DEPTH];
    logic [pld_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [pld_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [pld_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pld_pkg::QPTR_W'(pld_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + pld_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pld_pkg::QPTR_W'(pld_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + pld_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + pld_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - pld_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = store_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == pld_pkg::QCNT_W'(pld_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

FILE: rtl/pld_back.sv
// ----------------------------------------------------------------------------
// pld_back
// executes queued commands on the slot pool and drives the result register
// ----------------------------------------------------------------------------
`include "pooled_linked_deque_top_defines.svh"

module pld_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pld_pkg::qcmd_t  q_data,
    input  pld_pkg::qstat_t q_stat,
    output logic            q_pop,
    output logic            res_valid,
    input  logic            res_stall,
    output pld_pkg::res_t   res
);

    localparam int IW = pld_pkg::IDX_W;
    localparam int LW = pld_pkg::LINK_W;

    // pool memories
    logic signed [31:0] val_mem [pld_pkg::SLOTS];
    logic [LW-1:0]      fwd_mem [pld_pkg::SLOTS];
    logic [LW-1:0]      bwd_mem [pld_pkg::SLOTS];
    logic [pld_pkg::SLOTS-1:0] fwd_vld_reg;

    logic signed [31:0] val_rd_reg;
    logic [LW-1:0]      fwd_rd_reg;
    logic [LW-1:0]      bwd_rd_reg;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               val_we, fwd_we, bwd_we;
    logic [IW-1:0]      val_waddr, fwd_waddr, bwd_waddr;
    logic signed [31:0] val_wdata;
    logic [LW-1:0]      fwd_wdata, bwd_wdata;

    // control and list state
    pld_pkg::state_t    state_reg, state_next;
    logic [LW-1:0]      front_reg, front_next;
    logic [LW-1:0]      back_reg, back_next;
    logic [LW-1:0]      free_reg, free_next;
    pld_pkg::op_t       op_reg, op_next;
    logic signed [31:0] value_reg, value_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;
    pld_pkg::res_t      res_reg, res_next;

    logic               out_free;
    logic               front_null, back_null, free_null;
    logic               idle_err;
    logic [LW-1:0]      list_link;
    logic               list_done;
    logic [LW-1:0]      slot_link;

    assign out_free   = !res_valid_reg || !res_stall;
    assign front_null = (front_reg >= pld_pkg::NULL_LINK);
    assign back_null  = (back_reg >= pld_pkg::NULL_LINK);
    assign free_null  = (free_reg >= pld_pkg::NULL_LINK);
    assign slot_link  = LW'(slot_reg);
    assign list_link  = (op_reg == pld_pkg::OP_LIST_FWD) ? fwd_rd_reg : bwd_rd_reg;
    assign list_done  = (list_link >= pld_pkg::NULL_LINK)
                     || (cnt_reg == IW'(pld_pkg::SLOTS - 1));

    // command at the queue head answers with an error at once
    always_comb
    begin
        case (q_data.op)
            pld_pkg::OP_PUSH_FRONT,
            pld_pkg::OP_PUSH_BACK:  idle_err = free_null;
            pld_pkg::OP_POP_FRONT,
            pld_pkg::OP_LIST_FWD:   idle_err = front_null;
            pld_pkg::OP_POP_BACK,
            pld_pkg::OP_LIST_BWD:   idle_err = back_null;
            default:                idle_err = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pld_pkg::ST_IDLE:
            begin
                if (!q_stat.empty && !idle_err)
                begin
                    case (q_data.op)
                        pld_pkg::OP_PUSH_FRONT,
                        pld_pkg::OP_PUSH_BACK:  state_next = pld_pkg::ST_PUSH_RD;
                        pld_pkg::OP_POP_FRONT,
                        pld_pkg::OP_POP_BACK:   state_next = pld_pkg::ST_POP_RD;
                        default:                state_next = pld_pkg::ST_LIST;
                    endcase
                end
            end
            pld_pkg::ST_PUSH_RD:   state_next = pld_pkg::ST_PUSH_LINK;
            pld_pkg::ST_PUSH_LINK:
            begin
                if (out_free)
                begin
                    state_next = pld_pkg::ST_IDLE;
                end
            end
            pld_pkg::ST_POP_RD:
            begin
                if (out_free)
                begin
                    state_next = pld_pkg::ST_POP_FREE;
                end
            end
            pld_pkg::ST_POP_FREE:  state_next = pld_pkg::ST_IDLE;
            pld_pkg::ST_LIST:
            begin
                if (out_free && list_done)
                begin
                    state_next = pld_pkg::ST_IDLE;
                end
            end
            default:               state_next = pld_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        free_next      = free_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        val_we         = 1'b0;
        val_waddr      = slot_reg;
        val_wdata      = value_reg;
        fwd_we         = 1'b0;
        fwd_waddr      = slot_reg;
        fwd_wdata      = pld_pkg::NULL_LINK;
        bwd_we         = 1'b0;
        bwd_waddr      = slot_reg;
        bwd_wdata      = pld_pkg::NULL_LINK;

        case (state_reg)
            pld_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (idle_err)
                    begin
                        if (out_free)
                        begin
                            q_pop            = 1'b1;
                            res_valid_next   = 1'b1;
                            res_next.value_res = '0;
                            res_next.last    = 1'b1;
                            res_next.status  = (q_data.op == pld_pkg::OP_PUSH_FRONT
                                             || q_data.op == pld_pkg::OP_PUSH_BACK)
                                             ? pld_pkg::STAT_FULL : pld_pkg::STAT_EMPTY;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        op_next    = q_data.op;
                        value_next = q_data.value;
                        cnt_next   = '0;
                        rd_en      = 1'b1;
                        case (q_data.op)
                            pld_pkg::OP_PUSH_FRONT,
                            pld_pkg::OP_PUSH_BACK:  slot_next = free_reg[IW-1:0];
                            pld_pkg::OP_POP_FRONT,
                            pld_pkg::OP_LIST_FWD:   slot_next = front_reg[IW-1:0];
                            default:                slot_next = back_reg[IW-1:0];
                        endcase
                        rd_addr = slot_next;
                    end
                end
            end

            pld_pkg::ST_PUSH_RD:
            begin
                // new slot leaves the free list and takes its value
                free_next = fwd_rd_reg;
                val_we    = 1'b1;
                fwd_we    = 1'b1;
                bwd_we    = 1'b1;
                if (op_reg == pld_pkg::OP_PUSH_FRONT)
                begin
                    fwd_wdata = front_reg;
                    bwd_wdata = pld_pkg::NULL_LINK;
                end
                else
                begin
                    fwd_wdata = pld_pkg::NULL_LINK;
                    bwd_wdata = back_reg;
                end
            end

            pld_pkg::ST_PUSH_LINK:
            begin
                if (out_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.status    = pld_pkg::STAT_OK;
                    res_next.value_res = '0;
                    res_next.last      = 1'b1;
                    if (op_reg == pld_pkg::OP_PUSH_FRONT)
                    begin
                        if (!front_null)
                        begin
                            bwd_we    = 1'b1;
                            bwd_waddr = front_reg[IW-1:0];
                            bwd_wdata = slot_link;
                        end
                        else
                        begin
                            back_next = slot_link;
                        end
                        front_next = slot_link;
                    end
                    else
                    begin
                        if (!back_null)
                        begin
                            fwd_we    = 1'b1;
                            fwd_waddr = back_reg[IW-1:0];
                            fwd_wdata = slot_link;
                        end
                        else
                        begin
                            front_next = slot_link;
                        end
                        back_next = slot_link;
                    end
                end
            end

            pld_pkg::ST_POP_RD:
            begin
                if (out_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.status    = pld_pkg::STAT_OK;
                    res_next.value_res = val_rd_reg;
                    res_next.last      = 1'b1;
                    if (op_reg == pld_pkg::OP_POP_FRONT)
                    begin
                        front_next = fwd_rd_reg;
                        if (fwd_rd_reg < pld_pkg::NULL_LINK)
                        begin
                            bwd_we    = 1'b1;
                            bwd_waddr = fwd_rd_reg[IW-1:0];
                            bwd_wdata = pld_pkg::NULL_LINK;
                        end
                        else
                        begin
                            back_next = pld_pkg::NULL_LINK;
                        end
                    end
                    else
                    begin
                        back_next = bwd_rd_reg;
                        if (bwd_rd_reg < pld_pkg::NULL_LINK)
                        begin
                            fwd_we    = 1'b1;
                            fwd_waddr = bwd_rd_reg[IW-1:0];
                            fwd_wdata = pld_pkg::NULL_LINK;
                        end
                        else
                        begin
                            front_next = pld_pkg::NULL_LINK;
                        end
                    end
                end
            end

            pld_pkg::ST_POP_FREE:
            begin
                // freed slot goes back on top of the free list
                fwd_we    = 1'b1;
                fwd_wdata = free_reg;
                free_next = slot_link;
            end

            pld_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.status    = pld_pkg::STAT_OK;
                    res_next.value_res = val_rd_reg;
                    res_next.last      = list_done;
                    if (!list_done)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = list_link[IW-1:0];
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pld_pkg::ST_IDLE;
            front_reg     <= pld_pkg::NULL_LINK;
            back_reg      <= pld_pkg::NULL_LINK;
            free_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            free_reg      <= free_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    // forward links read as i+1 until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= '0;
        end
        else if (fwd_we)
        begin
            fwd_vld_reg[fwd_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bwd_we)
        begin
            bwd_mem[bwd_waddr] <= bwd_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            val_rd_reg <= val_mem[rd_addr];
            fwd_rd_reg <= fwd_vld_reg[rd_addr] ? fwd_mem[rd_addr]
                                               : LW'(rd_addr) + LW'(1);
            bwd_rd_reg <= bwd_mem[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `PLD_ASSERT_ALWAYS(a_ends_null_together, front_null == back_null, "list ends disagree")
    `PLD_ASSERT_IMPL(a_push_has_slot, state_reg == pld_pkg::ST_PUSH_RD, !free_null, "push without free slot")
    `PLD_ASSERT_IMPL(a_pop_has_item, state_reg == pld_pkg::ST_POP_RD, !front_null && !back_null, "pop on empty list")
    `PLD_ASSERT_IMPL(a_mid_listing, res_valid_reg && !res_reg.last, state_reg == pld_pkg::ST_LIST, "open result outside listing")

endmodule

FILE: rtl/pooled_linked_deque_top.sv
// push gives its result from the link state after the read state, pop from its read state
// error answers (pool full, list empty) come from the idle state, with no memory read
// a push or pop holds the back end until its read-then-link memory steps are done
// a listing visits one slot per cycle while the result side does not stall
// reset: async active low; list empty, all slots free, forward links valid at once
// ----------------------------------------------------------------------------
// pooled_linked_deque_top
// double-ended list in a fixed slot pool with forward/backward links and a
// free list; decoding front, two-entry command queue, executing back end
// ----------------------------------------------------------------------------
module pooled_linked_deque_top (
    input  logic          clk,
    input  logic          rst_n,
    // command beats
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pld_pkg::cmd_t cmd,
    // result beats
    output logic          res_valid,
    input  logic          res_stall,
    output pld_pkg::res_t res
);

    // front to queue
    logic            q_push;
    pld_pkg::qcmd_t  q_push_data;
    // queue to back
    logic            q_pop;
    pld_pkg::qcmd_t  q_head;
    pld_pkg::qstat_t q_stat;

    // decode kind, drop unknown ones, stall only on a full queue
    pld_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // decouples input beats from the memory sequencer
    pld_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_head),
        .stat      (q_stat)
    );

    // link memories, list ends, free list and result register
    pld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

FILE: tb/pooled_linked_deque_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled linked deque testbench
// drives push, pop and listing beats into the slot-pool deque, keeps a
// shadow pool with its own links and free chain, and checks every result beat
// ----------------------------------------------------------------------------
module pooled_linked_deque_top_tb;

    localparam int IW = pld_pkg::IDX_W;
    localparam int LW = pld_pkg::LINK_W;

    // cycles with no beat accepted on either side before the run is abandoned
    localparam int IDLE_LIMIT   = 1000;
    // quiet cycles after the last expected beat
    localparam int TAIL_CYCLES  = 3 * pld_pkg::SLOTS;
    // random beats that count (ignored kinds do not)
    localparam int RANDOM_BEATS = 410;
    // the two kinds that the block ignores
    localparam logic [2:0] KIND_UNUSED_A = 3'd6;
    localparam logic [2:0] KIND_UNUSED_B = 3'd7;

    // ------------------------------------------------------------------------
    // shadow deque: pool, links and free chain, plus the result beats owed
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        pld_pkg::res_t      owed_results[$];
        logic signed [31:0] slot_val [pld_pkg::SLOTS];
        logic [LW-1:0]      fwd_link [pld_pkg::SLOTS];
        logic [LW-1:0]      bwd_link [pld_pkg::SLOTS];
        logic [LW-1:0]      front_idx;
        logic [LW-1:0]      back_idx;
        logic [LW-1:0]      free_idx;
        int                 error_count;

        function new();
            for (int i = 0; i < pld_pkg::SLOTS; i++)
            begin
                slot_val[IW'(i)] = '0;
                bwd_link[IW'(i)] = pld_pkg::NULL_LINK;
                fwd_link[IW'(i)] = LW'(i + 1);
            end
            front_idx   = pld_pkg::NULL_LINK;
            back_idx    = pld_pkg::NULL_LINK;
            free_idx    = '0;
            error_count = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void owe(pld_pkg::status_t st, logic signed [31:0] v, logic lst);
            pld_pkg::res_t r;
            r.status    = st;
            r.value_res = v;
            r.last      = lst;
            owed_results.push_back(r);
        endfunction

        // accepted command beat: update the shadow pool, queue its results
        function void note_command(pld_pkg::cmd_t c);
            logic [LW-1:0] s;
            int            n;
            case (c.kind)
                pld_pkg::OP_PUSH_FRONT, pld_pkg::OP_PUSH_BACK:
                begin
                    if (free_idx == pld_pkg::NULL_LINK)
                        owe(pld_pkg::STAT_FULL, '0, 1'b1);
                    else
                    begin
                        s                  = free_idx;
                        free_idx           = fwd_link[s[IW-1:0]];
                        slot_val[s[IW-1:0]] = c.value;
                        if (c.kind == pld_pkg::OP_PUSH_FRONT)
                        begin
                            bwd_link[s[IW-1:0]] = pld_pkg::NULL_LINK;
                            fwd_link[s[IW-1:0]] = front_idx;
                            if (front_idx != pld_pkg::NULL_LINK)
                                bwd_link[front_idx[IW-1:0]] = s;
                            else
                                back_idx = s;
                            front_idx = s;
                        end
                        else
                        begin
                            fwd_link[s[IW-1:0]] = pld_pkg::NULL_LINK;
                            bwd_link[s[IW-1:0]] = back_idx;
                            if (back_idx != pld_pkg::NULL_LINK)
                                fwd_link[back_idx[IW-1:0]] = s;
                            else
                                front_idx = s;
                            back_idx = s;
                        end
                        owe(pld_pkg::STAT_OK, '0, 1'b1);
                    end
                end
                pld_pkg::OP_POP_FRONT, pld_pkg::OP_POP_BACK:
                begin
                    s = (c.kind == pld_pkg::OP_POP_FRONT) ? front_idx : back_idx;
                    if (s == pld_pkg::NULL_LINK)
                        owe(pld_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                    begin
                        if (c.kind == pld_pkg::OP_POP_FRONT)
                        begin
                            front_idx = fwd_link[s[IW-1:0]];
                            if (front_idx != pld_pkg::NULL_LINK)
                                bwd_link[front_idx[IW-1:0]] = pld_pkg::NULL_LINK;
                            else
                                back_idx = pld_pkg::NULL_LINK;
                        end
                        else
                        begin
                            back_idx = bwd_link[s[IW-1:0]];
                            if (back_idx != pld_pkg::NULL_LINK)
                                fwd_link[back_idx[IW-1:0]] = pld_pkg::NULL_LINK;
                            else
                                front_idx = pld_pkg::NULL_LINK;
                        end
                        fwd_link[s[IW-1:0]] = free_idx;
                        free_idx            = s;
                        owe(pld_pkg::STAT_OK, slot_val[s[IW-1:0]], 1'b1);
                    end
                end
                pld_pkg::OP_LIST_FWD, pld_pkg::OP_LIST_BWD:
                begin
                    s = (c.kind == pld_pkg::OP_LIST_FWD) ? front_idx : back_idx;
                    if (s == pld_pkg::NULL_LINK)
                        owe(pld_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                    begin
                        n = 0;
                        while (s != pld_pkg::NULL_LINK && n < pld_pkg::SLOTS)
                        begin
                            owe(pld_pkg::STAT_OK, slot_val[s[IW-1:0]], 1'b0);
                            n++;
                            s = (c.kind == pld_pkg::OP_LIST_FWD) ? fwd_link[s[IW-1:0]]
                                                                 : bwd_link[s[IW-1:0]];
                        end
                        owed_results[owed_results.size() - 1].last = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            error_count++;
            $display("%0t ns: %s mismatch, expected %h actual %h",
                     $time, field, exp_v, act_v);
        endfunction

        // accepted result beat: compare against the oldest owed one
        function void check_result(pld_pkg::res_t r);
            pld_pkg::res_t e;
            if (owed_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result, expected none actual %h/%h/%b",
                         $time, r.status, r.value_res, r.last);
                return;
            end
            e = owed_results.pop_front();
            if (r.status !== e.status)
                report("status", 32'(e.status), 32'(r.status));
            if (r.value_res !== e.value_res)
                report("value_res", e.value_res, r.value_res);
            if (r.last !== e.last)
                report("last", 32'(e.last), 32'(r.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    pld_pkg::cmd_t cmd       = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    pld_pkg::res_t res;

    deque_scoreboard sb = new();

    int idle_cycles = 0;   // cycles since the last accepted beat
    int burst_left  = 0;   // beats left in the current sender burst

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pooled_linked_deque_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // ------------------------------------------------------------------------
    // result side: stall pattern changes mode every so often
    // mode 0 never stalls, 1 stalls about a third of cycles,
    // 2 long stall runs, 3 toggles each cycle
    // ------------------------------------------------------------------------
    int stall_mode  = 0;
    int mode_left   = 100;
    int stall_run   = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 200);
        end
        mode_left--;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 2) == 0);
            2:
            begin
                // long stall runs separated by short open windows
                if (stall_run == 0)
                    stall_run = res_stall ? -$urandom_range(1, 4) : $urandom_range(1, 10);
                if (stall_run > 0)
                begin
                    res_stall <= 1'b1;
                    stall_run--;
                end
                else
                begin
                    res_stall <= 1'b0;
                    stall_run++;
                end
            end
            default: res_stall <= ~res_stall;
        endcase
    end

    // ------------------------------------------------------------------------
    // result monitor and idle counter, sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if (res_valid && !res_stall)
                sb.check_result(res);
            if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog: nothing moved for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // command side: bursts of random length with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_command(input pld_pkg::cmd_t c);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            // a quarter of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                cmd       <= '0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= c;
        // beat taken at the first rising edge without stall
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(c);
    endtask

    task automatic send_op(input pld_pkg::op_t k, input logic signed [31:0] v);
        pld_pkg::cmd_t c;
        c.kind  = k;
        c.value = v;
        send_command(c);
    endtask

    // random push value, with the extremes showing up now and then
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        pld_pkg::cmd_t c;
        int            counted;
        int            push_pct;
        int            r;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty list answers first
        send_op(pld_pkg::OP_LIST_FWD, '0);
        send_op(pld_pkg::OP_LIST_BWD, '0);
        send_op(pld_pkg::OP_POP_FRONT, '0);
        send_op(pld_pkg::OP_POP_BACK, '0);

        // fill the whole pool from both ends, extremes among the values
        send_op(pld_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_op(pld_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        send_op(pld_pkg::OP_PUSH_FRONT, -32'sd1);
        send_op(pld_pkg::OP_PUSH_BACK, '0);
        for (int i = 4; i < pld_pkg::SLOTS; i++)
            send_op((i % 2 == 0) ? pld_pkg::OP_PUSH_FRONT : pld_pkg::OP_PUSH_BACK, $urandom);

        // full pool refuses pushes on either end
        send_op(pld_pkg::OP_PUSH_FRONT, 32'sh1234_5678);
        send_op(pld_pkg::OP_PUSH_BACK, 32'sh1234_5678);

        // full-length walks in both directions, then one pop per end
        send_op(pld_pkg::OP_LIST_FWD, '0);
        send_op(pld_pkg::OP_LIST_BWD, '0);
        send_op(pld_pkg::OP_POP_FRONT, '0);
        send_op(pld_pkg::OP_POP_BACK, '0);

        // unused kinds are dropped with no answer
        c.kind  = KIND_UNUSED_A;
        c.value = 32'shffff_ffff;
        send_command(c);
        c.kind  = KIND_UNUSED_B;
        c.value = '0;
        send_command(c);

        // random: phases lean toward filling, draining or a mix so the
        // pool occupancy sweeps between empty and full repeatedly
        counted  = 0;
        push_pct = 50;
        while (counted < RANDOM_BEATS)
        begin
            if (counted % 40 == 0)
                case ($urandom_range(0, 2))
                    0:       push_pct = 75;
                    1:       push_pct = 25;
                    default: push_pct = 50;
                endcase
            r       = $urandom_range(0, 99);
            c.value = pick_value();
            if (r < 3)
            begin
                // noise beat, does not count
                c.kind = ($urandom_range(0, 1) == 0) ? KIND_UNUSED_A : KIND_UNUSED_B;
                send_command(c);
            end
            else
            begin
                if (r < 18)
                    c.kind = ($urandom_range(0, 1) == 0) ? pld_pkg::OP_LIST_FWD
                                                        : pld_pkg::OP_LIST_BWD;
                else if ($urandom_range(0, 99) < push_pct)
                    c.kind = ($urandom_range(0, 1) == 0) ? pld_pkg::OP_PUSH_FRONT
                                                        : pld_pkg::OP_PUSH_BACK;
                else
                    c.kind = ($urandom_range(0, 1) == 0) ? pld_pkg::OP_POP_FRONT
                                                        : pld_pkg::OP_POP_BACK;
                send_command(c);
                counted++;
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        cmd       <= '0;

        // drain, then leave room for a stray beat to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
